[src/wrs_pkg.sv]
package wrs_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 23;
    localparam int HEIGHT_W    = 24;
    localparam int COORD_W     = 9;
    localparam int GREY_W      = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [9:0]  RST_WIDTH_IN_USE  = 10'd400;
    localparam logic [9:0]  RST_HEIGHT_IN_USE = 10'd300;
    localparam logic [15:0] RST_DAMPING       = 16'd64881;
    localparam logic [22:0] RST_POKE_LEVEL    = 23'd409600;

    typedef enum logic [0:0] {
        OP_POKE    = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH      = 2'd0,
        REG_HEIGHT     = 2'd1,
        REG_DAMPING    = 2'd2,
        REG_POKE_LEVEL = 2'd3
    } reg_idx_t;

endpackage

[src/water_ripple_stencil_top.sv]
// Water ripple stencil: two height grids, one written and one read per frame.
// Input stream: s_axis_tuser selects poke or advance; a poke writes the poke
// level at (poke_x, poke_y) of the grid being written, an advance updates the
// next interior cell in raster order and yields one output beat.
// Output stream: cell position and grey level in tdata, tlast on the last
// interior cell of a frame, after which the two grids swap roles.
// Configuration: cfg_we/cfg_index/cfg_data, written while the block is idle.
// Each grid is split into even-column and odd-column banks with two read
// ports each, so the four neighbors and the cell's own old value are read in
// the same cycle: one item per cycle unless a hazard or output stall holds the input.
// An accepted advance passes through stage 1 (read and difference), stage 2
// (multiply) and stage 3 (round and write) to the output register.
// An advance whose cells are still being written by earlier items in flight
// is held off until those writes land, which mostly happens around a swap.
// Reset: both grids are cleared by a sweep over all 2**(clog2(MAX_HEIGHT) +
// clog2(MAX_WIDTH) - 1) bank addresses (131072 at 512 x 512), with s_axis_tready low.
// When the output stalls, pokes still pass on to their write while no advance
// waits in the last stage; once one does, the three stages fill and
// s_axis_tready drops; nothing is lost or reordered.
module water_ripple_stencil_top #(
    parameter int MAX_WIDTH  = wrs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wrs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [wrs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // poke_x, poke_y, zero pad
    input  logic [0:0]                         s_axis_tuser,   // opcode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [wrs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // cell_x, cell_y, grey_level, zero pad
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [wrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wrs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wrs_pkg::*;

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int XE     = XW + 1;
    localparam int YE     = YW + 1;
    localparam int BAW    = YW + XW - 1;
    localparam int BDEPTH = 2 ** BAW;

    localparam logic signed [26:0] H_MAX = 27'sd8388607;
    localparam logic signed [26:0] H_MIN = -27'sd8388608;

    typedef struct packed {
        logic          adv;
        logic          sel;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic          last;
    } item_t;

    // configuration
    logic [9:0]  width_in_use_reg;
    logic [9:0]  height_in_use_reg;
    logic [15:0] damping_reg;
    logic [22:0] poke_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_in_use_reg  <= RST_WIDTH_IN_USE;
            height_in_use_reg <= RST_HEIGHT_IN_USE;
            damping_reg       <= RST_DAMPING;
            poke_level_reg    <= RST_POKE_LEVEL;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_WIDTH:      width_in_use_reg  <= cfg_data[9:0];
                REG_HEIGHT:     height_in_use_reg <= cfg_data[9:0];
                REG_DAMPING:    damping_reg       <= cfg_data[15:0];
                REG_POKE_LEVEL: poke_level_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // effective grid size
    logic [XE-1:0] eff_w, wm2;
    logic [YE-1:0] eff_h, hm2;

    always_comb
    begin
        if (width_in_use_reg < 10'd3)
            eff_w = XE'(3);
        else if (32'(width_in_use_reg) > MAX_WIDTH)
            eff_w = XE'(MAX_WIDTH);
        else
            eff_w = XE'(width_in_use_reg);
        if (height_in_use_reg < 10'd3)
            eff_h = YE'(3);
        else if (32'(height_in_use_reg) > MAX_HEIGHT)
            eff_h = YE'(MAX_HEIGHT);
        else
            eff_h = YE'(height_in_use_reg);
        wm2 = eff_w - XE'(2);
        hm2 = eff_h - YE'(2);
    end

    // raster position and store roles
    logic          sel_reg;
    logic [XW-1:0] col_reg;
    logic [YW-1:0] row_reg;
    logic [XE-1:0] cx_e;
    logic [YE-1:0] ry_pre, ry_e;
    logic [XW-1:0] cx, xm1, xp1;
    logic [YW-1:0] ry, ym1, yp1;
    logic          col_wrap, last_cell;

    always_comb
    begin
        cx_e   = {1'b0, col_reg};
        ry_pre = {1'b0, row_reg};
        // position left beyond the interior after a size change
        if (col_reg == '0 || cx_e > wm2)
        begin
            cx_e   = XE'(1);
            ry_pre = {1'b0, row_reg} + YE'(1);
        end
        ry_e = ry_pre;
        if (ry_pre == '0 || ry_pre > hm2)
            ry_e = YE'(1);
        cx        = cx_e[XW-1:0];
        ry        = ry_e[YW-1:0];
        xm1       = cx - XW'(1);
        xp1       = cx + XW'(1);
        ym1       = ry - YW'(1);
        yp1       = ry + YW'(1);
        col_wrap  = (cx_e == wm2);
        last_cell = col_wrap && (ry_e == hm2);
    end

    // pipeline control
    logic  clr_active_reg;
    logic [BAW-1:0] clr_addr_reg;
    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    item_t s1_reg, s2_reg, s3_reg;
    logic  s1_free, s2_free, s3_free, out_free;
    logic  s1_go, s2_go, s3_go;
    logic  is_adv, poke_in, in_accept, hazard;
    item_t item_next;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s3_go    = s3_valid_reg && (!s3_reg.adv || out_free);
    assign s3_free  = !s3_valid_reg || s3_go;
    assign s2_go    = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s2_go;
    assign s1_go    = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_go;

    assign is_adv  = (s_axis_tuser == OP_ADVANCE);
    assign poke_in = (32'(s_axis_tdata[8:0]) < 32'(eff_w)) &&
                     (32'(s_axis_tdata[17:9]) < 32'(eff_h));

    // an advance must not read a cell whose write is still in flight
    item_t hz_i [3];
    logic  [2:0] hz_v;

    assign hz_i[0] = s1_reg;
    assign hz_i[1] = s2_reg;
    assign hz_i[2] = s3_reg;
    assign hz_v    = {s3_valid_reg, s2_valid_reg, s1_valid_reg};

    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (hz_v[k])
            begin
                if (hz_i[k].sel == sel_reg && hz_i[k].x == cx && hz_i[k].y == ry)
                    hazard = 1'b1;
                if (hz_i[k].sel != sel_reg &&
                    ((hz_i[k].x == cx && (hz_i[k].y == ym1 || hz_i[k].y == yp1)) ||
                     (hz_i[k].y == ry && (hz_i[k].x == xm1 || hz_i[k].x == xp1))))
                    hazard = 1'b1;
            end
        end
    end

    assign s_axis_tready = !clr_active_reg && s1_free && !(is_adv && hazard);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (is_adv)
        begin
            item_next.adv  = 1'b1;
            item_next.x    = cx;
            item_next.y    = ry;
            item_next.last = last_cell;
        end
        else
        begin
            item_next.adv  = 1'b0;
            item_next.x    = XW'(s_axis_tdata[8:0]);
            item_next.y    = YW'(s_axis_tdata[17:9]);
            item_next.last = 1'b0;
        end
        item_next.sel = sel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            sel_reg        <= 1'b0;
            col_reg        <= XW'(1);
            row_reg        <= YW'(1);
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + BAW'(1);
                if (&clr_addr_reg)
                    clr_active_reg <= 1'b0;
            end
            if (in_accept && is_adv)
            begin
                if (!col_wrap)
                begin
                    col_reg <= cx + XW'(1);
                    row_reg <= ry;
                end
                else
                begin
                    col_reg <= XW'(1);
                    if (last_cell)
                    begin
                        row_reg <= YW'(1);
                        sel_reg <= ~sel_reg;
                    end
                    else
                        row_reg <= yp1;
                end
            end
            if (s1_free)
                s1_valid_reg <= in_accept && (is_adv || poke_in);
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (out_free)
                out_valid_reg <= s3_go && s3_reg.adv;
        end
    end

    // height banks: store in bit 1 of the index, column parity in bit 0
    logic [BAW-1:0] addr_n, addr_s, addr_w, addr_e, addr_o, wa;
    logic [23:0]    rd0 [4];
    logic [23:0]    rd1 [4];
    logic [23:0]    wd;

    assign addr_n = {ym1, cx[XW-1:1]};
    assign addr_s = {yp1, cx[XW-1:1]};
    assign addr_w = {ry, xm1[XW-1:1]};
    assign addr_e = {ry, xp1[XW-1:1]};
    assign addr_o = {ry, cx[XW-1:1]};
    assign wa     = clr_active_reg ? clr_addr_reg : {s3_reg.y, s3_reg.x[XW-1:1]};

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        localparam logic BS = 1'(g / 2);
        localparam logic BB = 1'(g % 2);

        logic [23:0]    mem [BDEPTH];
        logic [23:0]    q0_reg, q1_reg;
        logic [BAW-1:0] ra0, ra1;
        logic           we;

        always_comb
        begin
            if (BS != sel_reg)
            begin
                if (BB == cx[0])
                begin
                    ra0 = addr_n;
                    ra1 = addr_s;
                end
                else
                begin
                    ra0 = addr_w;
                    ra1 = addr_e;
                end
            end
            else
            begin
                ra0 = addr_o;
                ra1 = addr_o;
            end
        end

        assign we = clr_active_reg ||
                    (s3_go && s3_reg.sel == BS && s3_reg.x[0] == BB);

        always_ff @(posedge clk)
        begin
            if (we)
                mem[wa] <= wd;
            if (in_accept)
            begin
                q0_reg <= mem[ra0];
                q1_reg <= mem[ra1];
            end
        end

        assign rd0[g] = q0_reg;
        assign rd1[g] = q1_reg;
    end

    // stage 1: neighbor sum minus twice the old value (half-lsb units)
    logic               rsel, xpar;
    logic signed [23:0] hn, hs, hw, he, ho;
    logic signed [26:0] d_next, d_reg;

    assign rsel   = ~s1_reg.sel;
    assign xpar   = s1_reg.x[0];
    assign hn     = $signed(rd0[{rsel, xpar}]);
    assign hs     = $signed(rd1[{rsel, xpar}]);
    assign hw     = $signed(rd0[{rsel, ~xpar}]);
    assign he     = $signed(rd1[{rsel, ~xpar}]);
    assign ho     = $signed(rd0[{s1_reg.sel, xpar}]);
    assign d_next = 27'(hn) + 27'(hs) + 27'(hw) + 27'(he) - 27'(ho) - 27'(ho);

    // stage 2: damping
    logic signed [43:0] p_next, p_reg;

    assign p_next = 44'(d_reg) * 44'($signed({1'b0, damping_reg}));

    // stage 3: round half up, saturate, grey level
    logic signed [43:0] rnd;
    logic signed [26:0] q;
    logic signed [23:0] nv;
    logic [12:0]        clip;
    logic [20:0]        grey_prod;

    always_comb
    begin
        rnd = p_reg + 44'sd65536;
        q   = 27'(rnd >>> 17);
        if (q > H_MAX)
            nv = 24'(H_MAX);
        else if (q < H_MIN)
            nv = 24'(H_MIN);
        else
            nv = 24'(q);
        if (nv < 24'sd0)
            clip = '0;
        else if (nv > 24'sd4096)
            clip = 13'd4096;
        else
            clip = nv[12:0];
        grey_prod = {clip, 8'b0} - {8'b0, clip};
    end

    assign wd = clr_active_reg ? '0 : (s3_reg.adv ? nv : {1'b0, poke_level_reg});

    // payload registers
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [GREY_W-1:0]  out_grey_reg;
    logic               out_last_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept && s1_free)
            s1_reg <= item_next;
        if (s1_go)
        begin
            s2_reg <= s1_reg;
            d_reg  <= d_next;
        end
        if (s2_go)
        begin
            s3_reg <= s2_reg;
            p_reg  <= p_next;
        end
        if (s3_go && s3_reg.adv && out_free)
        begin
            out_x_reg    <= COORD_W'(s3_reg.x);
            out_y_reg    <= COORD_W'(s3_reg.y);
            out_grey_reg <= grey_prod[19:12];
            out_last_reg <= s3_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_grey_reg, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[src/wrs_checker.sv]
module wrs_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [0:0]                      s_axis_tuser,   // opcode
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [wrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // cell_x, cell_y, grey_level, zero pad
    input  logic                            m_axis_tlast
);
    import wrs_pkg::*;

    // advances taken but not yet delivered
    logic [2:0] pending_reg;
    logic       adv_in, beat_out;

    assign adv_in   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_ADVANCE);
    assign beat_out = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (adv_in && !beat_out)
            pending_reg <= pending_reg + 3'd1;
        else if (beat_out && !adv_in)
            pending_reg <= pending_reg - 3'd1;
    end

    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_axis_tready)
        else $error("input taken while grids are being cleared");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_no_spurious_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 3'd0)
        else $error("output beat without a matching advance");

    a_bounded_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more advances in flight than pipeline stages");

endmodule

bind water_ripple_stencil_top wrs_checker u_wrs_checker (.*);
